// ===== rtl/gbs_pkg.sv =====
// Shared constants, types and helper functions of the granule burst splitter.
`timescale 1ns / 1ps
package gbs_pkg;

  localparam int GRANULE_BYTES     = 64;
  localparam int GRANULE_LOG       = 6;
  localparam int MAX_REQUEST_BYTES = 256;
  localparam int MAX_BURSTS        = 5;
  localparam int READ_CAP          = MAX_BURSTS * GRANULE_BYTES;
  localparam int PENDING_DEPTH_DEF = 8;

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 9;
  localparam int MASK_W = 64;
  localparam int ALU_W  = 10;
  localparam int BIDX_W = 3;
  localparam int BASE_W = ADDR_W - GRANULE_LOG;

  // Input word kinds.
  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_WDATA = 2'd1;
  localparam logic [1:0] KIND_RDATA = 2'd2;

  // Output word kinds.
  localparam logic [1:0] OUT_BURST  = 2'd0;
  localparam logic [1:0] OUT_WLANE  = 2'd1;
  localparam logic [1:0] OUT_RDATA  = 2'd2;
  localparam logic [1:0] OUT_RDONE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_END,
    ST_BURST,
    ST_WR_LANE,
    ST_RD_END,
    ST_RD_LO,
    ST_RD_HI,
    ST_RD_DATA,
    ST_RD_DONE
  } gbs_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   res;
    logic               borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic [GRANULE_LOG-1:0] push_off;
    logic [SIZE_W-1:0]      push_size;
  } fifo_ctl_t;

  typedef struct packed {
    logic                   empty;
    logic                   full;
    logic [GRANULE_LOG-1:0] head_off;
    logic [SIZE_W-1:0]      head_size;
  } fifo_stat_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [ADDR_W-1:0]      burst_addr;
    logic [MASK_W-1:0]      strobe_mask;
    logic                   burst_write;
    logic [GRANULE_LOG-1:0] lane;
    logic [7:0]             byte_out;
    logic [7:0]             byte_index;
    logic                   last;
  } gbs_res_t;

  // Ones in every lane below n; n of a full granule or more gives all ones.
  function automatic logic [MASK_W-1:0] gbs_below(input logic [GRANULE_LOG:0] n);
    logic [MASK_W-1:0] m;
    begin
      if (n[GRANULE_LOG]) begin
        m = '1;
      end else begin
        m = ~({MASK_W{1'b1}} << n[GRANULE_LOG-1:0]);
      end
      return m;
    end
  endfunction

endpackage

// ===== rtl/gbs_alu.sv =====
// Shared add and subtract unit used by the arithmetic steps of the sequencer.
`timescale 1ns / 1ps
module gbs_alu (
  input  gbs_pkg::alu_req_t req,
  output gbs_pkg::alu_rsp_t rsp
);
  import gbs_pkg::*;

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   sum;

  // Subtraction is a plus the complement of b plus one; a missing carry is a borrow.
  assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (req.op == ALU_SUB)};

  assign rsp.res    = sum[ALU_W-1:0];
  assign rsp.borrow = (req.op == ALU_SUB) & ~sum[ALU_W];

endmodule

// ===== rtl/gbs_pend_fifo.sv =====
// FIFO of pending reads holding each read's granule offset and size.
`timescale 1ns / 1ps
module gbs_pend_fifo #(
  parameter int DEPTH = gbs_pkg::PENDING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gbs_pkg::fifo_ctl_t   ctl,
  output gbs_pkg::fifo_stat_t  stat
);
  import gbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [GRANULE_LOG-1:0] off_mem [DEPTH];
  logic [SIZE_W-1:0]      size_mem[DEPTH];

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    begin
      if (p == PTR_W'(DEPTH - 1)) begin
        return '0;
      end else begin
        return p + PTR_W'(1);
      end
    end
  endfunction

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.push) begin
      tail_nxt = ptr_inc(tail_r);
    end
    if (ctl.pop) begin
      head_nxt = ptr_inc(head_r);
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      off_mem[tail_r]  <= ctl.push_off;
      size_mem[tail_r] <= ctl.push_size;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.head_off  = off_mem[head_r];
  assign stat.head_size = size_mem[head_r];

endmodule

// ===== rtl/gbs_ctrl.sv =====
// Sequencer that steps each word through the shared adder and builds the result words.
`timescale 1ns / 1ps
module gbs_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [gbs_pkg::ADDR_W-1:0]        in_request_addr,
  input  logic [gbs_pkg::SIZE_W-1:0]        in_request_size,
  input  logic                              in_request_write,
  input  logic [7:0]                        in_byte_in,
  input  logic                              slot_free,
  output logic                              res_valid,
  output gbs_pkg::gbs_res_t                 res,
  output gbs_pkg::alu_req_t                 alu_req,
  input  gbs_pkg::alu_rsp_t                 alu_rsp,
  output gbs_pkg::fifo_ctl_t                fifo_ctl,
  input  gbs_pkg::fifo_stat_t               fifo_stat
);
  import gbs_pkg::*;

  gbs_state_t             state_r,     state_nxt;
  logic [BASE_W-1:0]      base_r,      base_nxt;
  logic [GRANULE_LOG-1:0] off_r,       off_nxt;
  logic [SIZE_W-1:0]      size_r,      size_nxt;
  logic                   wr_r,        wr_nxt;
  logic [7:0]             byte_r,      byte_nxt;
  logic [ALU_W-1:0]       rem_r,       rem_nxt;
  logic [BIDX_W-1:0]      gidx_r,      gidx_nxt;
  logic [GRANULE_LOG-1:0] write_off_r, write_off_nxt;
  logic [SIZE_W-1:0]      write_pos_r, write_pos_nxt;
  logic [SIZE_W-1:0]      read_pos_r,  read_pos_nxt;
  logic [ALU_W-1:0]       end_r,       end_nxt;
  logic [7:0]             idx_r,       idx_nxt;
  logic                   ge_r,        ge_nxt;
  logic                   inrng_r,     inrng_nxt;
  logic                   done_r,      done_nxt;

  logic [SIZE_W-1:0]      size_sat;
  logic [SIZE_W-1:0]      pos1;
  logic [GRANULE_LOG:0]   lane_hi;
  logic [GRANULE_LOG:0]   lane_lo;
  logic                   burst_last;

  assign size_sat = (in_request_size > SIZE_W'(MAX_REQUEST_BYTES)) ?
                    SIZE_W'(MAX_REQUEST_BYTES) : in_request_size;
  assign pos1     = read_pos_r + SIZE_W'(1);

  assign lane_hi    = (rem_r >= ALU_W'(GRANULE_BYTES)) ?
                      (GRANULE_LOG+1)'(GRANULE_BYTES) : rem_r[GRANULE_LOG:0];
  assign lane_lo    = (gidx_r == '0) ? {1'b0, off_r} : '0;
  assign burst_last = (rem_r <= ALU_W'(GRANULE_BYTES)) ||
                      (gidx_r == BIDX_W'(MAX_BURSTS - 1));

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    off_nxt       = off_r;
    size_nxt      = size_r;
    wr_nxt        = wr_r;
    byte_nxt      = byte_r;
    rem_nxt       = rem_r;
    gidx_nxt      = gidx_r;
    write_off_nxt = write_off_r;
    write_pos_nxt = write_pos_r;
    read_pos_nxt  = read_pos_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    ge_nxt        = ge_r;
    inrng_nxt     = inrng_r;
    done_nxt      = done_r;
    in_ready      = (state_r == ST_IDLE);
    res_valid     = 1'b0;
    res           = '0;
    alu_req       = '{op: ALU_ADD, a: '0, b: '0};
    fifo_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_HDR: begin
              if ((in_request_size != '0) && (in_request_write || !fifo_stat.full)) begin
                base_nxt  = in_request_addr[ADDR_W-1:GRANULE_LOG];
                off_nxt   = in_request_addr[GRANULE_LOG-1:0];
                size_nxt  = size_sat;
                wr_nxt    = in_request_write;
                state_nxt = ST_HDR_END;
                if (in_request_write) begin
                  write_off_nxt = in_request_addr[GRANULE_LOG-1:0];
                  write_pos_nxt = '0;
                end else begin
                  fifo_ctl.push      = 1'b1;
                  fifo_ctl.push_off  = in_request_addr[GRANULE_LOG-1:0];
                  fifo_ctl.push_size = size_sat;
                end
              end
            end
            KIND_WDATA: begin
              byte_nxt  = in_byte_in;
              state_nxt = ST_WR_LANE;
            end
            KIND_RDATA: begin
              if (!fifo_stat.empty) begin
                byte_nxt  = in_byte_in;
                state_nxt = ST_RD_END;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_HDR_END: begin
        // End of the request measured from the first granule's base.
        alu_req   = '{op: ALU_ADD, a: ALU_W'(off_r), b: ALU_W'(size_r)};
        rem_nxt   = alu_rsp.res;
        gidx_nxt  = '0;
        state_nxt = ST_BURST;
      end

      ST_BURST: begin
        alu_req = '{op: ALU_SUB, a: rem_r, b: ALU_W'(GRANULE_BYTES)};
        if (slot_free) begin
          res_valid       = 1'b1;
          res.kind        = OUT_BURST;
          res.burst_addr  = {base_r, {GRANULE_LOG{1'b0}}};
          res.strobe_mask = gbs_below(lane_hi) & ~gbs_below(lane_lo);
          res.burst_write = wr_r;
          res.last        = burst_last;
          rem_nxt         = alu_rsp.res;
          base_nxt        = base_r + BASE_W'(1);
          gidx_nxt        = gidx_r + BIDX_W'(1);
          if (burst_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_WR_LANE: begin
        alu_req = '{op: ALU_ADD, a: ALU_W'(write_off_r), b: ALU_W'(write_pos_r)};
        if (slot_free) begin
          res_valid     = 1'b1;
          res.kind      = OUT_WLANE;
          res.lane      = alu_rsp.res[GRANULE_LOG-1:0];
          res.byte_out  = byte_r;
          write_pos_nxt = write_pos_r + SIZE_W'(1);
          state_nxt     = ST_IDLE;
        end
      end

      ST_RD_END: begin
        alu_req   = '{op: ALU_ADD, a: ALU_W'(fifo_stat.head_off),
                      b: ALU_W'(fifo_stat.head_size)};
        end_nxt   = alu_rsp.res;
        state_nxt = ST_RD_LO;
      end

      ST_RD_LO: begin
        alu_req   = '{op: ALU_SUB, a: ALU_W'(read_pos_r), b: ALU_W'(fifo_stat.head_off)};
        ge_nxt    = ~alu_rsp.borrow;
        idx_nxt   = alu_rsp.res[7:0];
        state_nxt = ST_RD_HI;
      end

      ST_RD_HI: begin
        // One subtract of the next position against the end gives both the
        // upper range check and whether the last needed granule is complete.
        alu_req   = '{op: ALU_SUB, a: ALU_W'(pos1), b: end_r};
        inrng_nxt = ge_r && (alu_rsp.borrow || (alu_rsp.res == '0));
        done_nxt  = (pos1[GRANULE_LOG-1:0] == '0) &&
                    (!alu_rsp.borrow || (pos1 == SIZE_W'(READ_CAP)));
        state_nxt = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        if (!inrng_r || slot_free) begin
          if (inrng_r) begin
            res_valid      = 1'b1;
            res.kind       = OUT_RDATA;
            res.byte_out   = byte_r;
            res.byte_index = idx_r;
          end
          if (done_r) begin
            state_nxt = ST_RD_DONE;
          end else begin
            read_pos_nxt = pos1;
            state_nxt    = ST_IDLE;
          end
        end
      end

      ST_RD_DONE: begin
        if (slot_free) begin
          res_valid    = 1'b1;
          res.kind     = OUT_RDONE;
          read_pos_nxt = '0;
          fifo_ctl.pop = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      write_off_r <= '0;
      write_pos_r <= '0;
      read_pos_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      write_off_r <= write_off_nxt;
      write_pos_r <= write_pos_nxt;
      read_pos_r  <= read_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    off_r   <= off_nxt;
    size_r  <= size_nxt;
    wr_r    <= wr_nxt;
    byte_r  <= byte_nxt;
    rem_r   <= rem_nxt;
    gidx_r  <= gidx_nxt;
    end_r   <= end_nxt;
    idx_r   <= idx_nxt;
    ge_r    <= ge_nxt;
    inrng_r <= inrng_nxt;
    done_r  <= done_nxt;
  end

endmodule

// ===== rtl/granule_burst_splitter_top.sv =====
// Top level of the granule burst splitter: sequencer, shared adder, read FIFO, output register.
//
//   Channel | Direction | Handshake            | Word contents
//   --------+-----------+----------------------+------------------------------------------
//   in_     | input     | in_valid / in_ready   | kind, request address/size/write, byte
//   out_    | output    | out_valid / out_ready | kind, burst addr, strobes, lane, byte, index
//
// A request header is taken, then has its end found in the shared adder in ST_HDR_END, and
// then gives one burst command per ST_BURST step while the output is free, for n bursts in
// all (n is at most five). A write data word passes through ST_WR_LANE, a read response
// word through ST_RD_END, ST_RD_LO, ST_RD_HI and ST_RD_DATA, plus ST_RD_DONE when it closes
// the head read, and a word that is dropped is only taken. The steps are set by the single
// adder, which does one add or subtract per cycle for the sequencer.
// Reset is synchronous and active low; it empties the pending read FIFO and clears
// the write lane and read position counters.
// When out_ready is low and the output register is full the sequencer holds in its current
// emitting step; the register loads a new word in the same cycle that the last one is taken.
`timescale 1ns / 1ps
module granule_burst_splitter_top #(
  parameter int PENDING_DEPTH = gbs_pkg::PENDING_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_kind,
  input  logic [gbs_pkg::ADDR_W-1:0]           in_request_addr,
  input  logic [gbs_pkg::SIZE_W-1:0]           in_request_size,
  input  logic                                 in_request_write,
  input  logic [7:0]                           in_byte_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_kind,
  output logic [gbs_pkg::ADDR_W-1:0]           out_burst_addr,
  output logic [gbs_pkg::MASK_W-1:0]           out_strobe_mask,
  output logic                                 out_burst_write,
  output logic [gbs_pkg::GRANULE_LOG-1:0]      out_lane,
  output logic [7:0]                           out_byte_out,
  output logic [7:0]                           out_byte_index,
  output logic                                 out_last
);
  import gbs_pkg::*;

  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;
  fifo_ctl_t  fifo_ctl;
  fifo_stat_t fifo_stat;
  gbs_res_t   res;
  logic       res_valid;
  logic       slot_free;

  // The output register holds one result word; it is free when empty or
  // when its word is being taken in this cycle.
  logic       out_valid_r, out_valid_nxt;
  gbs_res_t   out_res_r;

  assign slot_free = !out_valid_r || out_ready;

  gbs_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_request_addr  (in_request_addr),
    .in_request_size  (in_request_size),
    .in_request_write (in_request_write),
    .in_byte_in       (in_byte_in),
    .slot_free        (slot_free),
    .res_valid        (res_valid),
    .res              (res),
    .alu_req          (alu_req),
    .alu_rsp          (alu_rsp),
    .fifo_ctl         (fifo_ctl),
    .fifo_stat        (fifo_stat)
  );

  gbs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gbs_pend_fifo #(
    .DEPTH (PENDING_DEPTH)
  ) u_pend_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fifo_ctl),
    .stat  (fifo_stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_res_r.kind;
  assign out_burst_addr  = out_res_r.burst_addr;
  assign out_strobe_mask = out_res_r.strobe_mask;
  assign out_burst_write = out_res_r.burst_write;
  assign out_lane        = out_res_r.lane;
  assign out_byte_out    = out_res_r.byte_out;
  assign out_byte_index  = out_res_r.byte_index;
  assign out_last        = out_res_r.last;

endmodule

// ===== verif/granule_burst_splitter_top_test.sv =====
// Self-checking testbench of the granule burst splitter: directed rows, random sequences, stalls.
`timescale 1ns / 1ps
module granule_burst_splitter_top_test;
  import gbs_pkg::*;

  // The input kind that the block has no use for; it must vanish without a word out.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_PCT     = 19;
  localparam int ITEM_BUDGET  = 260;
  localparam int FILL_RESERVE = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int FIFO_SLOTS   = PENDING_DEPTH_DEF;

  // One row of the directed part. When typed is set, the row carries its own answer
  // (has_word says whether the row yields one word at all) instead of the predictor's.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [8:0]  size;
    logic        wr;
    logic [7:0]  data;
    bit          typed;
    bit          has_word;
    gbs_res_t    word;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = KIND_HDR;
  logic [31:0] in_request_addr = '0;
  logic [8:0]  in_request_size = '0;
  logic        in_request_write = 1'b0;
  logic [7:0]  in_byte_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_burst_addr;
  logic [63:0] out_strobe_mask;
  logic        out_burst_write;
  logic [5:0]  out_lane;
  logic [7:0]  out_byte_out;
  logic [7:0]  out_byte_index;
  logic        out_last;

  // Both sides read these flags at the clock edge, so they are only ever written with
  // nonblocking assignments.
  logic steady = 1'b0;
  logic hold_go = 1'b0;
  logic hold_active = 1'b0;

  granule_burst_splitter_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_request_addr  (in_request_addr),
    .in_request_size  (in_request_size),
    .in_request_write (in_request_write),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_burst_addr   (out_burst_addr),
    .out_strobe_mask  (out_strobe_mask),
    .out_burst_write  (out_burst_write),
    .out_lane         (out_lane),
    .out_byte_out     (out_byte_out),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // ---------------------------------------------------------------------------
  // Splitter predictor. It keeps its own copy of the pending read FIFO and of the
  // write lane and read position counters, and turns one accepted word into the
  // words the block must send, left in split_words.
  // ---------------------------------------------------------------------------
  logic [5:0] rd_off [FIFO_SLOTS];
  logic [8:0] rd_size [FIFO_SLOTS];
  int         rd_head = 0;
  int         rd_tail = 0;
  int         rd_count = 0;
  logic [8:0] rd_pos = '0;
  logic [8:0] wr_pos = '0;
  logic [5:0] wr_off = '0;

  gbs_res_t split_words[$];
  gbs_res_t due_words[$];
  int       words_sent = 0;
  int       words_seen = 0;
  int       failures = 0;

  // Number of granules that a request touches, never more than MAX_BURSTS.
  function automatic int burst_span(int offv, int sz);
    int n;
    n = 1 + ((offv + sz - 1) >> GRANULE_LOG);
    if (n > MAX_BURSTS) begin
      n = MAX_BURSTS;
    end
    return n;
  endfunction

  function automatic void note_word(gbs_res_t w);
    split_words.insert(split_words.size(), w);
  endfunction

  function automatic void queue_due(gbs_res_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic void split_request(logic [1:0] kind, logic [31:0] addr, logic [8:0] size,
                                        logic wr, logic [7:0] data);
    int       offv;
    int       sz;
    int       n;
    int       p;
    int       total;
    gbs_res_t w;
    split_words.delete();
    case (kind)
      KIND_HDR: begin
        offv = int'(addr[GRANULE_LOG-1:0]);
        sz = int'(size);
        // A zero-length request is a no-op; oversized ones are clipped.
        if (sz == 0) begin
          return;
        end
        if (sz > MAX_REQUEST_BYTES) begin
          sz = MAX_REQUEST_BYTES;
        end
        // A read header that finds the pending FIFO full is dropped whole.
        if (!wr && rd_count >= FIFO_SLOTS) begin
          return;
        end
        n = burst_span(offv, sz);
        for (int g = 0; g < n; g++) begin
          w = '0;
          w.kind = OUT_BURST;
          // The aligned base plus whole granules; the sum wraps at 32 bits.
          w.burst_addr = {addr[31:GRANULE_LOG], {GRANULE_LOG{1'b0}}} + 32'(g * GRANULE_BYTES);
          for (int ln = 0; ln < GRANULE_BYTES; ln++) begin
            p = g * GRANULE_BYTES + ln;
            if (p >= offv && p < offv + sz) begin
              w.strobe_mask[ln] = 1'b1;
            end
          end
          w.burst_write = wr;
          w.last = (g == n - 1);
          note_word(w);
        end
        if (wr) begin
          wr_off = offv[5:0];
          wr_pos = '0;
        end else begin
          rd_off[rd_tail] = offv[5:0];
          rd_size[rd_tail] = sz[8:0];
          rd_tail = (rd_tail + 1) % FIFO_SLOTS;
          rd_count++;
        end
      end
      KIND_WDATA: begin
        // Lanes run on from the last write header's offset and wrap in the granule.
        w = '0;
        w.kind = OUT_WLANE;
        w.lane = wr_off + wr_pos[5:0];
        w.byte_out = data;
        wr_pos = wr_pos + 9'd1;
        note_word(w);
      end
      KIND_RDATA: begin
        if (rd_count == 0) begin
          return;
        end
        offv = int'(rd_off[rd_head]);
        sz = int'(rd_size[rd_head]);
        total = burst_span(offv, sz) * GRANULE_BYTES;
        // Bytes inside the request are delivered, padding around it is dropped.
        if (int'(rd_pos) >= offv && int'(rd_pos) < offv + sz) begin
          w = '0;
          w.kind = OUT_RDATA;
          w.byte_out = data;
          w.byte_index = 8'(int'(rd_pos) - offv);
          note_word(w);
        end
        rd_pos = rd_pos + 9'd1;
        if (int'(rd_pos) >= total) begin
          w = '0;
          w.kind = OUT_RDONE;
          note_word(w);
          rd_pos = '0;
          rd_head = (rd_head + 1) % FIFO_SLOTS;
          rd_count--;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every word taken from the block is matched against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    failures++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("word %0d %s is %0h, should be %0h", words_seen, name, got,
                              want));
    end
  endtask

  gbs_res_t due_word;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        flag_mismatch($sformatf("word %0d of kind %0d arrived with nothing due", words_seen,
                                out_kind));
      end else begin
        due_word = due_words[0];
        due_words.delete(0);
        compare_field("kind", 64'(out_kind), 64'(due_word.kind));
        compare_field("burst_addr", 64'(out_burst_addr), 64'(due_word.burst_addr));
        compare_field("strobe_mask", out_strobe_mask, due_word.strobe_mask);
        compare_field("burst_write", 64'(out_burst_write), 64'(due_word.burst_write));
        compare_field("lane", 64'(out_lane), 64'(due_word.lane));
        compare_field("byte_out", 64'(out_byte_out), 64'(due_word.byte_out));
        compare_field("byte_index", 64'(out_byte_index), 64'(due_word.byte_index));
        compare_field("last", 64'(out_last), 64'(due_word.last));
      end
      words_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls at random, about one time in five, never while the steady window is
  // open, and stays stalled throughout the long hold-off, which runs in its own process.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_active) begin
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long hold-off: the receiver stays away while the sender keeps offering words, so
  // the output register and the sequencer back up and in_ready drops.
  initial begin
    while (!hold_go) begin
      @(posedge clk);
    end
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender. Each call starts on a clock edge, may first idle at random, then holds the word
  // until it is taken, and hands it to the predictor at that edge.
  // ---------------------------------------------------------------------------
  task automatic offer_word(input logic [1:0] kind, input logic [31:0] addr,
                            input logic [8:0] size, input logic wr, input logic [7:0] data,
                            input bit typed = 1'b0, input bit has_word = 1'b0,
                            input gbs_res_t word = '0);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_request_addr <= addr;
    in_request_size <= size;
    in_request_write <= wr;
    in_byte_in <= data;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    split_request(kind, addr, size, wr, data);
    if (typed) begin
      if (has_word) begin
        queue_due(word);
      end
    end else begin
      foreach (split_words[i]) begin
        queue_due(split_words[i]);
      end
    end
    words_sent++;
  endtask

  // A word of the given kind with every other field random.
  task automatic offer_filler(input logic [1:0] kind);
    offer_word(kind, $urandom(), 9'($urandom_range(511)), 1'($urandom_range(1)),
               8'($urandom_range(255)));
  endtask

  // True while the random part may still send words.
  function automatic bit room();
    return (words_sent < ITEM_BUDGET - FILL_RESERVE);
  endfunction

  // The sender stops offering until the block has delivered every word still due.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (due_words.size() != 0);
  endtask

  // A write header with random placement, followed by its data bytes. Now and then the
  // data run is cut short or overruns the request, which the lane counter must survive.
  task automatic write_burst();
    logic [8:0] size;
    int         pick;
    int         count;
    pick = $urandom_range(99);
    if (pick < 70) begin
      size = 9'($urandom_range(1, 48));
    end else if (pick < 80) begin
      size = 9'($urandom_range(49, MAX_REQUEST_BYTES));
    end else if (pick < 90) begin
      size = 9'($urandom_range(MAX_REQUEST_BYTES + 1, 511));
    end else begin
      size = '0;
    end
    offer_word(KIND_HDR, $urandom(), size, 1'b1, 8'($urandom_range(255)));
    count = (size > 9'd64) ? 64 : int'(size);
    if ($urandom_range(99) < 15) begin
      count = $urandom_range(0, count + 6);
    end
    for (int k = 0; k < count && room(); k++) begin
      offer_filler(KIND_WDATA);
    end
  endtask

  // One to three read headers, then the memory bytes that answer them. The usual case
  // returns every burst byte while the budget lasts; sometimes the stream stops early
  // and is finished later.
  task automatic read_batch();
    int reads;
    int sz;
    reads = $urandom_range(1, 3);
    repeat (reads) begin
      sz = ($urandom_range(99) < 90) ? $urandom_range(1, 64) : $urandom_range(65, 320);
      offer_word(KIND_HDR, $urandom(), sz[8:0], 1'b0, 8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 40)) offer_filler(KIND_RDATA);
    end else begin
      while (rd_count != 0 && room()) begin
        offer_filler(KIND_RDATA);
      end
    end
  endtask

  // Fills the pending read FIFO, offers two more read headers that must be dropped and a word of
  // the unused kind, answers queued reads while the budget lasts and sends one more response byte.
  task automatic fill_pending_fifo();
    while (rd_count < FIFO_SLOTS) begin
      offer_word(KIND_HDR, $urandom(), 9'($urandom_range(1, 16)), 1'b0,
                 8'($urandom_range(255)));
    end
    repeat (2) offer_word(KIND_HDR, $urandom(), 9'($urandom_range(1, 511)), 1'b0,
                          8'($urandom_range(255)));
    offer_filler(KIND_UNUSED);
    while (rd_count != 0 && words_sent < ITEM_BUDGET) begin
      offer_filler(KIND_RDATA);
    end
    offer_filler(KIND_RDATA);
  endtask

  function automatic stim_row_t stim(logic [1:0] kind, logic [31:0] addr, logic [8:0] size,
                                     logic wr, logic [7:0] data, bit typed = 1'b0,
                                     bit has_word = 1'b0, gbs_res_t word = '0);
    stim_row_t r;
    r.kind = kind;
    r.addr = addr;
    r.size = size;
    r.wr = wr;
    r.data = data;
    r.typed = typed;
    r.has_word = has_word;
    r.word = word;
    return r;
  endfunction

  function automatic gbs_res_t res_word(logic [1:0] kind, logic [31:0] addr, logic [63:0] mask,
                                        logic wr, logic [5:0] lane, logic [7:0] data,
                                        logic last);
    gbs_res_t w;
    w = '0;
    w.kind = kind;
    w.burst_addr = addr;
    w.strobe_mask = mask;
    w.burst_write = wr;
    w.lane = lane;
    w.byte_out = data;
    w.last = last;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, a pause until everything is out, the random
  // part with the hold-off at its start and a steady window in its middle, then the
  // full pending FIFO, and the final drain.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows[$];

  function automatic void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  initial begin
    int pick;
    int random_start;
    int done_rnd;

    // A write byte, a read byte and an unused word straight after reset: lane 0, and nothing to answer.
    add_row(stim(KIND_WDATA, 32'h0, 9'd0, 1'b0, 8'hA5, 1'b1, 1'b1,
                 res_word(OUT_WLANE, 32'h0, 64'h0, 1'b0, 6'd0, 8'hA5, 1'b0)));
    add_row(stim(KIND_RDATA, 32'h0, 9'd0, 1'b0, 8'h11, 1'b1));
    add_row(stim(KIND_UNUSED, 32'hFFFF_FFFF, 9'h1FF, 1'b1, 8'hFF, 1'b1));
    // Zero-length write header: no burst, and the lane counter keeps running.
    add_row(stim(KIND_HDR, 32'h0000_1234, 9'd0, 1'b1, 8'h00, 1'b1));
    // One byte in the top lane of the top granule.
    add_row(stim(KIND_HDR, 32'hFFFF_FFFF, 9'd1, 1'b1, 8'h00, 1'b1, 1'b1,
                 res_word(OUT_BURST, 32'hFFFF_FFC0, 64'h8000_0000_0000_0000,
                          1'b1, 6'd0, 8'h00, 1'b1)));
    add_row(stim(KIND_WDATA, 32'h0, 9'd0, 1'b0, 8'hFF, 1'b1, 1'b1,
                 res_word(OUT_WLANE, 32'h0, 64'h0, 1'b0, 6'd63, 8'hFF, 1'b0)));
    // The lane wraps inside the granule.
    add_row(stim(KIND_WDATA, 32'h0, 9'd0, 1'b0, 8'h00, 1'b1, 1'b1,
                 res_word(OUT_WLANE, 32'h0, 64'h0, 1'b0, 6'd0, 8'h00, 1'b0)));
    // Largest legal request, aligned: four full-strobe bursts.
    add_row(stim(KIND_HDR, 32'h0000_0000, 9'd256, 1'b1, 8'h00));
    add_row(stim(KIND_WDATA, 32'h0, 9'd0, 1'b0, 8'h3C, 1'b1, 1'b1,
                 res_word(OUT_WLANE, 32'h0, 64'h0, 1'b0, 6'd0, 8'h3C, 1'b0)));
    // Oversized and unaligned near the top of memory: clipped, five bursts, address wrap.
    add_row(stim(KIND_HDR, 32'hFFFF_FFC1, 9'h1FF, 1'b1, 8'h00));
    add_row(stim(KIND_WDATA, 32'h0, 9'd0, 1'b0, 8'h5A));
    add_row(stim(KIND_WDATA, 32'h0, 9'd0, 1'b0, 8'hC3));
    // Read headers: small, wrapping over the top, a single byte, and the maximum span.
    add_row(stim(KIND_HDR, 32'h0000_0005, 9'd3, 1'b0, 8'h00));
    add_row(stim(KIND_HDR, 32'hFFFF_FFF0, 9'd20, 1'b0, 8'h00));
    add_row(stim(KIND_HDR, 32'h8000_0000, 9'd1, 1'b0, 8'h00, 1'b1, 1'b1,
                 res_word(OUT_BURST, 32'h8000_0000, 64'h1, 1'b0, 6'd0, 8'h00, 1'b1)));
    add_row(stim(KIND_HDR, 32'h7FFF_FFFF, 9'd256, 1'b0, 8'h00));
    // First response bytes of the head read: padding, then the first data bytes.
    for (int b = 0; b < 8; b++) begin
      add_row(stim(KIND_RDATA, 32'h0, 9'd0, 1'b0, 8'(8'hF0 + b)));
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].size,
                 directed_rows[i].wr, directed_rows[i].data, directed_rows[i].typed,
                 directed_rows[i].has_word, directed_rows[i].word);
    end
    wait_drained();

    // Random part. The hold-off starts at once, while write runs keep the input busy.
    hold_go <= 1'b1;
    random_start = words_sent;
    while (room()) begin
      done_rnd = words_sent - random_start;
      steady <= (done_rnd >= 90 && done_rnd < 170);
      pick = $urandom_range(99);
      if (done_rnd < 40 || pick < 40) begin
        write_burst();
      end else if (pick < 70) begin
        read_batch();
      end else begin
        offer_filler(2'($urandom_range(3)));
      end
    end
    steady <= 1'b0;
    fill_pending_fifo();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && due_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

endmodule
